[rtl/cle_pkg.sv]
// Package for the cursor list engine: field widths, op and status codes,
// the sequencer state type and the empty-cursor code. No dependencies.
`default_nettype none

package cle_pkg;

	// Number of list elements. The result fields are sized for up to 64.
	localparam int CAPACITY = 64;

	localparam int OP_W     = 4;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 7;
	localparam int POS_W    = 7;

	// Cursor position reported when the cursor is undefined (-1).
	localparam logic [POS_W-1:0] CURSOR_NONE = '1;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR       = 4'd0,
		OP_PREPEND     = 4'd1,
		OP_APPEND      = 4'd2,
		OP_INS_BEFORE  = 4'd3,
		OP_INS_AFTER   = 4'd4,
		OP_DEL_FRONT   = 4'd5,
		OP_DEL_BACK    = 4'd6,
		OP_DEL_CURSOR  = 4'd7,
		OP_SET         = 4'd8,
		OP_MOVE_FRONT  = 4'd9,
		OP_MOVE_BACK   = 4'd10,
		OP_MOVE_PREV   = 4'd11,
		OP_MOVE_NEXT   = 4'd12,
		OP_QUERY       = 4'd13
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_NOCUR = 2'd2,
		STAT_FULL  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SHIFT,
		S_PUT,
		S_RD_FRONT,
		S_RD_BACK,
		S_RD_CUR,
		S_FINISH
	} state_t;

endpackage

`default_nettype wire

[rtl/cle_if.sv]
// Handshake channels of the cursor list engine: the op word and the result
// word. Widths come from cle_pkg.
`default_nettype none

interface cle_cmd_if;
	logic                              valid;
	logic                              ready;
	logic [cle_pkg::OP_W-1:0]          op;
	logic signed [cle_pkg::VALUE_W-1:0] value;

	modport source (output valid, op, value, input ready);
	modport sink   (input valid, op, value, output ready);
endinterface

interface cle_rsp_if;
	logic                                valid;
	logic                                ready;
	logic [cle_pkg::STATUS_W-1:0]        status;
	logic [cle_pkg::COUNT_W-1:0]         count;
	logic signed [cle_pkg::POS_W-1:0]    cursor_position;
	logic signed [cle_pkg::VALUE_W-1:0]  front_value;
	logic signed [cle_pkg::VALUE_W-1:0]  back_value;
	logic signed [cle_pkg::VALUE_W-1:0]  cursor_value;

	modport source (output valid, status, count, cursor_position, front_value, back_value,
		cursor_value, input ready);
	modport sink   (input valid, status, count, cursor_position, front_value, back_value,
		cursor_value, output ready);
endinterface

`default_nettype wire

[rtl/cursor_list_engine.sv]
// Cursor list engine top level: element memory, list state and op sequencer.
// Depends on cle_pkg and on the channel interfaces in cle_if.sv.
//
// Usage. Ops arrive as words on the cmd channel (op code and value) and each
// op yields exactly one result word on the rsp channel: status, element count,
// cursor position (-1 when undefined) and the front, back and cursor values.
// A word moves on a rising edge of clk at which valid and ready are both high.
// The block works on one op at a time. An op that moves no element (clear,
// set, del_back, the moves and query) goes from decode straight to the read
// back of the result values; set writes the memory during decode.
// Inserts and deletes move the tail one element per cycle through the single
// read and write port of the element memory; the number of elements moved
// (none for append) stays below CAPACITY.
// The front, back and cursor values are read back from the memory after the
// op, one read per cycle. cmd.ready rises at the same edge that places the
// result in the output register.
// Reset (arst_n low) empties the list and leaves the cursor undefined; the
// element memory is not cleared, as no entry at or above the count reaches
// a result. If the receiver stalls, the result waits in the output register
// and the next op may still be accepted and worked on; it is held back only
// at its final step until the previous result has been taken.
`default_nettype none

module cursor_list_engine (
	input  wire         clk,
	input  wire         arst_n,
	cle_cmd_if.sink     cmd,
	cle_rsp_if.source   rsp
);

	localparam int AW = $clog2(cle_pkg::CAPACITY);
	localparam int CW = $clog2(cle_pkg::CAPACITY + 1);

	// Sequencer and list state.
	cle_pkg::state_t state_q, state_d;

	logic [CW-1:0] count_q;
	logic          cur_def_q;
	logic [AW-1:0] cur_idx_q;

	// The op being worked on.
	logic [cle_pkg::OP_W-1:0]    op_q;
	logic [cle_pkg::VALUE_W-1:0] value_q;
	logic [cle_pkg::STATUS_W-1:0] st_q;

	// Shift sweep: read pointer, reads left to issue, direction and the
	// pending write one stage behind the read.
	logic [AW-1:0] ptr_q;
	logic [CW-1:0] left_q;
	logic          up_q;
	logic          put_q;
	logic [AW-1:0] pos_q;
	logic          wr_v_s1;
	logic [AW-1:0] wr_addr_s1;

	// Element memory with registered read data.
	logic [cle_pkg::VALUE_W-1:0] mem [cle_pkg::CAPACITY];
	logic [cle_pkg::VALUE_W-1:0] rd_data_q;
	logic                        rd_en;
	logic [AW-1:0]               rd_addr;
	logic                        we;
	logic [AW-1:0]               wa;
	logic [cle_pkg::VALUE_W-1:0] wd;

	logic [cle_pkg::VALUE_W-1:0] front_q, back_q;

	// Output register.
	logic                          out_valid_q;
	logic [cle_pkg::STATUS_W-1:0]  out_status_q;
	logic [cle_pkg::COUNT_W-1:0]   out_count_q;
	logic [cle_pkg::POS_W-1:0]     out_pos_q;
	logic [cle_pkg::VALUE_W-1:0]   out_front_q, out_back_q, out_cur_q;

	// Decode of the current op against the list state.
	logic                          empty, full;
	logic [CW-1:0]                 cnt_m1;
	logic [AW-1:0]                 last_idx;
	logic [CW-1:0]                 nx_count;
	logic                          nx_def;
	logic [AW-1:0]                 nx_idx;
	logic [cle_pkg::STATUS_W-1:0]  nx_st;
	logic                          do_open, do_close, do_set;
	logic [AW-1:0]                 gap_pos;
	logic [AW-1:0]                 init_ptr;
	logic [CW-1:0]                 init_left;
	logic                          load_out;

	assign empty    = (count_q == '0);
	assign full     = (count_q == CW'(cle_pkg::CAPACITY));
	assign cnt_m1   = count_q - CW'(1);
	assign last_idx = AW'(cnt_m1);

	always_comb begin
		nx_count = count_q;
		nx_def   = cur_def_q;
		nx_idx   = cur_idx_q;
		nx_st    = cle_pkg::STAT_OK;
		do_open  = 1'b0;
		do_close = 1'b0;
		do_set   = 1'b0;
		gap_pos  = '0;
		case (op_q)
			cle_pkg::OP_CLEAR: begin
				nx_count = '0;
				nx_def   = 1'b0;
				nx_idx   = '0;
			end
			cle_pkg::OP_PREPEND: begin
				if (full) begin
					nx_st = cle_pkg::STAT_FULL;
				end else begin
					do_open  = 1'b1;
					nx_count = count_q + CW'(1);
					if (cur_def_q) begin
						nx_idx = cur_idx_q + AW'(1);
					end
				end
			end
			cle_pkg::OP_APPEND: begin
				if (full) begin
					nx_st = cle_pkg::STAT_FULL;
				end else begin
					do_open  = 1'b1;
					gap_pos  = AW'(count_q);
					nx_count = count_q + CW'(1);
				end
			end
			cle_pkg::OP_INS_BEFORE, cle_pkg::OP_INS_AFTER: begin
				if (empty) begin
					nx_st = cle_pkg::STAT_EMPTY;
				end else if (!cur_def_q) begin
					nx_st = cle_pkg::STAT_NOCUR;
				end else if (full) begin
					nx_st = cle_pkg::STAT_FULL;
				end else begin
					do_open  = 1'b1;
					nx_count = count_q + CW'(1);
					if (op_q == cle_pkg::OP_INS_BEFORE) begin
						gap_pos = cur_idx_q;
						nx_idx  = cur_idx_q + AW'(1);
					end else begin
						gap_pos = cur_idx_q + AW'(1);
					end
				end
			end
			cle_pkg::OP_DEL_FRONT: begin
				if (empty) begin
					nx_st = cle_pkg::STAT_EMPTY;
				end else begin
					do_close = 1'b1;
					nx_count = cnt_m1;
					if (cur_def_q) begin
						if (cur_idx_q == '0) begin
							nx_def = 1'b0;
						end else begin
							nx_idx = cur_idx_q - AW'(1);
						end
					end
				end
			end
			cle_pkg::OP_DEL_BACK: begin
				if (empty) begin
					nx_st = cle_pkg::STAT_EMPTY;
				end else begin
					nx_count = cnt_m1;
					if (cur_def_q && cur_idx_q == last_idx) begin
						nx_def = 1'b0;
						nx_idx = '0;
					end
				end
			end
			cle_pkg::OP_DEL_CURSOR: begin
				if (empty) begin
					nx_st = cle_pkg::STAT_EMPTY;
				end else if (!cur_def_q) begin
					nx_st = cle_pkg::STAT_NOCUR;
				end else begin
					do_close = 1'b1;
					gap_pos  = cur_idx_q;
					nx_count = cnt_m1;
					nx_def   = 1'b0;
					nx_idx   = '0;
				end
			end
			cle_pkg::OP_SET: begin
				if (empty) begin
					nx_st = cle_pkg::STAT_EMPTY;
				end else if (!cur_def_q) begin
					nx_st = cle_pkg::STAT_NOCUR;
				end else begin
					do_set = 1'b1;
				end
			end
			cle_pkg::OP_MOVE_FRONT, cle_pkg::OP_MOVE_BACK: begin
				if (empty) begin
					nx_st = cle_pkg::STAT_EMPTY;
				end else begin
					nx_def = 1'b1;
					nx_idx = (op_q == cle_pkg::OP_MOVE_FRONT) ? '0 : last_idx;
				end
			end
			cle_pkg::OP_MOVE_PREV: begin
				if (empty) begin
					nx_st = cle_pkg::STAT_EMPTY;
				end else if (cur_def_q) begin
					if (cur_idx_q == '0) begin
						nx_def = 1'b0;
					end else begin
						nx_idx = cur_idx_q - AW'(1);
					end
				end
			end
			cle_pkg::OP_MOVE_NEXT: begin
				if (empty) begin
					nx_st = cle_pkg::STAT_EMPTY;
				end else if (cur_def_q) begin
					if (cur_idx_q == last_idx) begin
						nx_def = 1'b0;
						nx_idx = '0;
					end else begin
						nx_idx = cur_idx_q + AW'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	// An insert moves the tail up, starting from the last element; a delete
	// moves it down, starting just above the removed element.
	always_comb begin
		if (do_open) begin
			init_ptr  = last_idx;
			init_left = count_q - CW'(gap_pos);
		end else begin
			init_ptr  = gap_pos + AW'(1);
			init_left = cnt_m1 - CW'(gap_pos);
		end
	end

	assign load_out = (state_q == cle_pkg::S_FINISH) && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cle_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and the memory port controls.
	always_comb begin
		state_d = state_q;
		rd_en   = 1'b0;
		rd_addr = '0;
		we      = 1'b0;
		wa      = '0;
		wd      = value_q;
		case (state_q)
			cle_pkg::S_IDLE: begin
				if (cmd.valid) begin
					state_d = cle_pkg::S_EXEC;
				end
			end
			cle_pkg::S_EXEC: begin
				if (do_set) begin
					we = 1'b1;
					wa = cur_idx_q;
				end
				state_d = (do_open || do_close) ? cle_pkg::S_SHIFT : cle_pkg::S_RD_FRONT;
			end
			cle_pkg::S_SHIFT: begin
				if (left_q != '0) begin
					rd_en   = 1'b1;
					rd_addr = ptr_q;
				end
				if (wr_v_s1) begin
					we = 1'b1;
					wa = wr_addr_s1;
					wd = rd_data_q;
				end
				if (left_q == '0 && !wr_v_s1) begin
					state_d = put_q ? cle_pkg::S_PUT : cle_pkg::S_RD_FRONT;
				end
			end
			cle_pkg::S_PUT: begin
				we      = 1'b1;
				wa      = pos_q;
				state_d = cle_pkg::S_RD_FRONT;
			end
			cle_pkg::S_RD_FRONT: begin
				rd_en   = 1'b1;
				state_d = cle_pkg::S_RD_BACK;
			end
			cle_pkg::S_RD_BACK: begin
				rd_en   = 1'b1;
				rd_addr = last_idx;
				state_d = cle_pkg::S_RD_CUR;
			end
			cle_pkg::S_RD_CUR: begin
				rd_en   = 1'b1;
				rd_addr = cur_idx_q;
				state_d = cle_pkg::S_FINISH;
			end
			cle_pkg::S_FINISH: begin
				if (load_out) begin
					state_d = cle_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = cle_pkg::S_IDLE;
			end
		endcase
	end

	assign cmd.ready = (state_q == cle_pkg::S_IDLE);

	// Element memory: one write and one read a cycle, read data held when
	// no read is issued so that the cursor value survives a stalled output.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// List state and sweep control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cur_def_q   <= 1'b0;
			cur_idx_q   <= '0;
			left_q      <= '0;
			wr_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == cle_pkg::S_EXEC) begin
				count_q   <= nx_count;
				cur_def_q <= nx_def;
				cur_idx_q <= nx_def ? nx_idx : '0;
				left_q    <= (do_open || do_close) ? init_left : '0;
				wr_v_s1   <= 1'b0;
			end else if (state_q == cle_pkg::S_SHIFT) begin
				wr_v_s1 <= (left_q != '0);
				if (left_q != '0) begin
					left_q <= left_q - CW'(1);
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == cle_pkg::S_IDLE && cmd.valid) begin
			op_q    <= cmd.op;
			value_q <= cmd.value;
		end
		if (state_q == cle_pkg::S_EXEC) begin
			st_q  <= nx_st;
			ptr_q <= init_ptr;
			pos_q <= gap_pos;
			up_q  <= do_open;
			put_q <= do_open;
		end
		if (state_q == cle_pkg::S_SHIFT && left_q != '0) begin
			wr_addr_s1 <= up_q ? ptr_q + AW'(1) : ptr_q - AW'(1);
			ptr_q      <= up_q ? ptr_q - AW'(1) : ptr_q + AW'(1);
		end
		if (state_q == cle_pkg::S_RD_BACK) begin
			front_q <= rd_data_q;
		end
		if (state_q == cle_pkg::S_RD_CUR) begin
			back_q <= rd_data_q;
		end
		if (load_out) begin
			out_status_q <= st_q;
			out_count_q  <= cle_pkg::COUNT_W'(count_q);
			out_pos_q    <= cur_def_q ? cle_pkg::POS_W'(cur_idx_q) : cle_pkg::CURSOR_NONE;
			out_front_q  <= empty ? '0 : front_q;
			out_back_q   <= empty ? '0 : back_q;
			out_cur_q    <= cur_def_q ? rd_data_q : '0;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.status          = out_status_q;
	assign rsp.count           = out_count_q;
	assign rsp.cursor_position = out_pos_q;
	assign rsp.front_value     = out_front_q;
	assign rsp.back_value      = out_back_q;
	assign rsp.cursor_value    = out_cur_q;

endmodule

`default_nettype wire

[rtl/cle_checker.sv]
// Port-level checks for the cursor list engine and the bind that attaches
// them to cursor_list_engine. Depends on cle_pkg for field widths.
`default_nettype none

module cle_checker (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              cmd_valid,
	input wire                              cmd_ready,
	input wire                              rsp_valid,
	input wire                              rsp_ready,
	input wire [cle_pkg::STATUS_W-1:0]      rsp_status,
	input wire [cle_pkg::COUNT_W-1:0]       rsp_count,
	input wire [cle_pkg::POS_W-1:0]         rsp_cursor_position,
	input wire [cle_pkg::VALUE_W-1:0]       rsp_front_value,
	input wire [cle_pkg::VALUE_W-1:0]       rsp_back_value,
	input wire [cle_pkg::VALUE_W-1:0]       rsp_cursor_value
);

	// A stalled result word keeps its status, count and cursor fields.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_count)
			&& $stable(rsp_cursor_position) && $stable(rsp_cursor_value))
		else $error("result word changed while stalled");

	// Only one op is in flight: ready drops after every accepted op word.
	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("op word accepted while another is in flight");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_count <= cle_pkg::COUNT_W'(cle_pkg::CAPACITY))
		else $error("count beyond capacity");

	// An empty list has no cursor and reports zero at both ends.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_count == '0 |-> rsp_cursor_position == cle_pkg::CURSOR_NONE
			&& rsp_front_value == '0 && rsp_back_value == '0)
		else $error("empty list reports an element");

	// A defined cursor lies inside the list.
	a_cursor_inside: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_cursor_position != cle_pkg::CURSOR_NONE
			|-> rsp_cursor_position < rsp_count)
		else $error("cursor beyond the end of the list");

endmodule

bind cursor_list_engine cle_checker u_cle_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.cmd_valid           (cmd.valid),
	.cmd_ready           (cmd.ready),
	.rsp_valid           (rsp.valid),
	.rsp_ready           (rsp.ready),
	.rsp_status          (rsp.status),
	.rsp_count           (rsp.count),
	.rsp_cursor_position (rsp.cursor_position),
	.rsp_front_value     (rsp.front_value),
	.rsp_back_value      (rsp.back_value),
	.rsp_cursor_value    (rsp.cursor_value)
);

`default_nettype wire

[tb/sv/tb_cursor_list_engine.sv]
`timescale 1ns / 1ps
// Self-checking testbench for cursor_list_engine: a directed table followed by random op bursts.
// Depends on cle_pkg, the channel interfaces in cle_if.sv and the engine top level.

module tb_cursor_list_engine;

	import cle_pkg::*;

	localparam int RANDOM_ITEMS    = 750;
	// Spare op codes above the last defined op; the engine treats them as a query.
	localparam logic [OP_W-1:0] OP_SPARE_LO = 4'd14;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 4'd15;
	// Cycles with no word moving on either channel before the run is declared hung.
	// The slowest op moves CAPACITY - 1 elements, and stalls and gaps on either
	// side are drawn by pick_gap.
	localparam int WATCHDOG_LIMIT  = 2000;
	// Quiet time after the last result, enough for a full-length shift to show up.
	localparam int DRAIN_CYCLES    = CAPACITY + 16;

	localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

	// One result word as the engine reports it.
	typedef struct {
		logic [STATUS_W-1:0]         status;
		logic [COUNT_W-1:0]          count;
		logic signed [POS_W-1:0]     cursor_position;
		logic signed [VALUE_W-1:0]   front_value;
		logic signed [VALUE_W-1:0]   back_value;
		logic signed [VALUE_W-1:0]   cursor_value;
	} list_view_t;

	// One row of the directed table. Rows marked fixed carry a hand-written result;
	// the others are checked against the list model below.
	typedef struct {
		logic [OP_W-1:0]           code;
		logic signed [VALUE_W-1:0] value;
		bit                        fixed;
		list_view_t                want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	cle_cmd_if cmd_ch ();
	cle_rsp_if rsp_ch ();

	cursor_list_engine u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	// Shadow copy of the list kept by the testbench.
	logic signed [VALUE_W-1:0] list_vals [CAPACITY];
	int unsigned               list_len;
	bit                        cursor_on;
	int unsigned               cursor_at;

	list_view_t  pending_results [$];
	stim_row_t   directed_rows [$];
	int          fail_count;
	int          quiet_cycles;
	// Set for whole bursts during which neither side idles.
	bit          no_idle;

	// Clock and the single reset at the start of the run.
	initial begin
		clk = 1'b0;
	end

	always #10 clk = ~clk;

	initial begin
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Make room at pos by moving the tail up one place, then store v there.
	function automatic void open_gap(input int unsigned pos, input logic signed [VALUE_W-1:0] v);
		for (int unsigned i = list_len; i > pos; i--) begin
			list_vals[i] = list_vals[i - 1];
		end
		list_vals[pos] = v;
		list_len++;
	endfunction

	// Remove the element at pos by moving the tail down one place.
	function automatic void close_gap(input int unsigned pos);
		for (int unsigned i = pos; i + 1 < list_len; i++) begin
			list_vals[i] = list_vals[i + 1];
		end
		list_len--;
	endfunction

	// Apply one op to the shadow list and return the result word that the engine
	// should produce for it. Error checks run in the order empty, no cursor, full,
	// and a failed check leaves the list untouched.
	function automatic list_view_t apply_list_op(input logic [OP_W-1:0] code,
			input logic signed [VALUE_W-1:0] v);
		list_view_t r;
		status_t    st;
		bit         empty;
		bit         full;
		bit         cur;
		st    = STAT_OK;
		empty = (list_len == 0);
		full  = (list_len >= CAPACITY);
		cur   = cursor_on && (cursor_at < list_len);
		case (code)
			OP_CLEAR: begin
				list_len  = 0;
				cursor_on = 1'b0;
				cursor_at = 0;
			end
			OP_PREPEND: begin
				if (full) begin
					st = STAT_FULL;
				end else begin
					// The cursor stays on its element, which has moved up one place.
					open_gap(0, v);
					if (cur) begin
						cursor_at++;
					end
				end
			end
			OP_APPEND: begin
				if (full) begin
					st = STAT_FULL;
				end else begin
					open_gap(list_len, v);
				end
			end
			OP_INS_BEFORE, OP_INS_AFTER: begin
				if (empty) begin
					st = STAT_EMPTY;
				end else if (!cur) begin
					st = STAT_NOCUR;
				end else if (full) begin
					st = STAT_FULL;
				end else if (code == OP_INS_BEFORE) begin
					open_gap(cursor_at, v);
					cursor_at++;
				end else begin
					open_gap(cursor_at + 1, v);
				end
			end
			OP_DEL_FRONT: begin
				if (empty) begin
					st = STAT_EMPTY;
				end else begin
					close_gap(0);
					if (cur) begin
						if (cursor_at == 0) begin
							cursor_on = 1'b0;
						end else begin
							cursor_at--;
						end
					end
				end
			end
			OP_DEL_BACK: begin
				if (empty) begin
					st = STAT_EMPTY;
				end else begin
					if (cur && cursor_at == list_len - 1) begin
						cursor_on = 1'b0;
					end
					list_len--;
				end
			end
			OP_DEL_CURSOR: begin
				if (empty) begin
					st = STAT_EMPTY;
				end else if (!cur) begin
					st = STAT_NOCUR;
				end else begin
					close_gap(cursor_at);
					cursor_on = 1'b0;
				end
			end
			OP_SET: begin
				if (empty) begin
					st = STAT_EMPTY;
				end else if (!cur) begin
					st = STAT_NOCUR;
				end else begin
					list_vals[cursor_at] = v;
				end
			end
			OP_MOVE_FRONT, OP_MOVE_BACK: begin
				if (empty) begin
					st = STAT_EMPTY;
				end else begin
					cursor_on = 1'b1;
					cursor_at = (code == OP_MOVE_FRONT) ? 0 : list_len - 1;
				end
			end
			OP_MOVE_PREV: begin
				if (empty) begin
					st = STAT_EMPTY;
				end else if (cur) begin
					// Stepping off the front leaves the cursor undefined.
					if (cursor_at == 0) begin
						cursor_on = 1'b0;
					end else begin
						cursor_at--;
					end
				end
			end
			OP_MOVE_NEXT: begin
				if (empty) begin
					st = STAT_EMPTY;
				end else if (cur) begin
					if (cursor_at + 1 >= list_len) begin
						cursor_on = 1'b0;
					end else begin
						cursor_at++;
					end
				end
			end
			default: begin
			end
		endcase
		cur = cursor_on && (cursor_at < list_len);
		if (!cur) begin
			cursor_on = 1'b0;
			cursor_at = 0;
		end
		r.status          = st;
		r.count           = COUNT_W'(list_len);
		r.cursor_position = cur ? POS_W'(cursor_at) : CURSOR_NONE;
		r.front_value     = (list_len != 0) ? list_vals[0] : '0;
		r.back_value      = (list_len != 0) ? list_vals[list_len - 1] : '0;
		r.cursor_value    = cur ? list_vals[cursor_at] : '0;
		return r;
	endfunction

	function automatic void add_row(input logic [OP_W-1:0] code,
			input logic signed [VALUE_W-1:0] v);
		stim_row_t row;
		row.code  = code;
		row.value = v;
		row.fixed = 1'b0;
		row.want  = '{default: '0};
		directed_rows.push_back(row);
	endfunction

	function automatic void add_fixed_row(input logic [OP_W-1:0] code,
			input logic signed [VALUE_W-1:0] v, input status_t st, input int cnt,
			input int pos, input logic signed [VALUE_W-1:0] front,
			input logic signed [VALUE_W-1:0] back, input logic signed [VALUE_W-1:0] cval);
		stim_row_t row;
		row.code                 = code;
		row.value                = v;
		row.fixed                = 1'b1;
		row.want.status          = st;
		row.want.count           = COUNT_W'(cnt);
		row.want.cursor_position = POS_W'(pos);
		row.want.front_value     = front;
		row.want.back_value      = back;
		row.want.cursor_value    = cval;
		directed_rows.push_back(row);
	endfunction

	// Idle length: mostly none, often a few cycles, now and then a long one.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	// Values lean on the extremes and on zero and minus one.
	function automatic logic signed [VALUE_W-1:0] random_value();
		case ($urandom_range(0, 9))
			0:       return VAL_MAX;
			1:       return VAL_MIN;
			2:       return '0;
			3:       return '1;
			default: return $urandom;
		endcase
	endfunction

	// Op mix per burst mode: 0 grows the list towards full, 1 drains it, anything
	// else is an even spread with the odd clear.
	function automatic logic [OP_W-1:0] random_op(input int unsigned mode);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (mode == 0) begin
			if (r < 30) return OP_APPEND;
			if (r < 45) return OP_PREPEND;
			if (r < 60) return OP_INS_BEFORE;
			if (r < 72) return OP_INS_AFTER;
			if (r < 80) return $urandom_range(0, 1) ? OP_MOVE_FRONT : OP_MOVE_BACK;
			if (r < 86) return OP_MOVE_NEXT;
			if (r < 90) return OP_MOVE_PREV;
			if (r < 94) return OP_SET;
			if (r < 97) return OP_DEL_CURSOR;
			return OP_DEL_FRONT;
		end else if (mode == 1) begin
			if (r < 25) return OP_DEL_FRONT;
			if (r < 50) return OP_DEL_BACK;
			if (r < 70) return OP_DEL_CURSOR;
			if (r < 80) return $urandom_range(0, 1) ? OP_MOVE_FRONT : OP_MOVE_BACK;
			if (r < 88) return $urandom_range(0, 1) ? OP_MOVE_NEXT : OP_MOVE_PREV;
			if (r < 93) return OP_APPEND;
			if (r < 97) return OP_SET;
			return OP_QUERY;
		end
		if (r == 0) return OP_CLEAR;
		return OP_W'($urandom_range(OP_PREPEND, OP_SPARE_HI));
	endfunction

	// Present one op word, wait for the engine to take it, and record the result
	// word it should produce. The valid line is only lowered when a gap is taken,
	// so it is never lowered and raised within the same time step.
	task automatic send_word(input logic [OP_W-1:0] code, input logic signed [VALUE_W-1:0] v,
			input bit fixed, input list_view_t want);
		int unsigned gap;
		list_view_t  predicted;
		gap = no_idle ? 0 : pick_gap();
		if (gap != 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.op    <= code;
		cmd_ch.value <= v;
		cmd_ch.valid <= 1'b1;
		do @(posedge clk); while (!cmd_ch.ready);
		predicted = apply_list_op(code, v);
		pending_results.push_back(fixed ? want : predicted);
	endtask

	// Op side: the directed table, then random bursts, then the drain and verdict.
	initial begin : op_source
		list_view_t  no_view;
		int unsigned sent;
		int unsigned mode;
		int unsigned burst;
		cmd_ch.valid = 1'b0;
		cmd_ch.op    = OP_QUERY;
		cmd_ch.value = '0;
		no_idle      = 1'b0;
		no_view      = '{default: '0};
		fail_count   = 0;
		list_len     = 0;
		cursor_on    = 1'b0;
		cursor_at    = 0;
		sent         = 0;

		// Empty list straight after reset, and a delete, a set and a move that need elements.
		add_fixed_row(OP_QUERY,      '0,      STAT_OK,    0, -1, '0, '0, '0);
		add_fixed_row(OP_DEL_FRONT,  '0,      STAT_EMPTY, 0, -1, '0, '0, '0);
		add_fixed_row(OP_SET,        32'sd99, STAT_EMPTY, 0, -1, '0, '0, '0);
		add_fixed_row(OP_MOVE_NEXT,  '0,      STAT_EMPTY, 0, -1, '0, '0, '0);
		// Extreme values at both ends, then an insert and a delete that need a cursor, without one.
		add_fixed_row(OP_APPEND,     VAL_MAX, STAT_OK,    1, -1, VAL_MAX, VAL_MAX, '0);
		add_fixed_row(OP_PREPEND,    VAL_MIN, STAT_OK,    2, -1, VAL_MIN, VAL_MAX, '0);
		add_fixed_row(OP_INS_BEFORE, 32'sd3,  STAT_NOCUR, 2, -1, VAL_MIN, VAL_MAX, '0);
		add_fixed_row(OP_DEL_CURSOR, '0,      STAT_NOCUR, 2, -1, VAL_MIN, VAL_MAX, '0);
		// A step with no cursor on a list that has elements changes nothing; move back sets one.
		add_row(OP_MOVE_PREV, '0);
		add_row(OP_MOVE_BACK, '0);
		// Inserts on both sides of the cursor; the insert before shifts it up.
		add_row(OP_INS_BEFORE, 32'sd5);
		add_row(OP_INS_AFTER, '1);
		// Walking off the back and off the front leaves the cursor undefined.
		add_row(OP_MOVE_NEXT, '0);
		add_row(OP_MOVE_NEXT, '0);
		add_row(OP_MOVE_FRONT, '0);
		add_row(OP_MOVE_PREV, '0);
		// Deleting the element under the cursor from either end, a set and a delete at the cursor, and the spare codes.
		add_row(OP_MOVE_FRONT, '0);
		add_row(OP_DEL_FRONT, '0);
		add_row(OP_MOVE_BACK, '0);
		add_row(OP_DEL_BACK, '0);
		add_row(OP_MOVE_FRONT, '0);
		add_row(OP_SET, 32'sh1234_5678);
		add_row(OP_DEL_CURSOR, '0);
		add_row(OP_SPARE_LO, '0);
		add_row(OP_SPARE_HI, '0);
		add_fixed_row(OP_CLEAR,      '0,      STAT_OK,    0, -1, '0, '0, '0);

		wait (arst_n);
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_word(directed_rows[i].code, directed_rows[i].value, directed_rows[i].fixed,
				directed_rows[i].want);
		end

		// Random bursts. Growth bursts can run long enough to fill the list from empty
		// and then hit it with inserts while full; drain bursts shrink it again.
		while (sent < RANDOM_ITEMS) begin
			mode    = $urandom_range(0, 3);
			no_idle = ($urandom_range(0, 5) == 0);
			burst   = (mode < 2) ? $urandom_range(40, 110) : $urandom_range(15, 50);
			if (burst > RANDOM_ITEMS - sent) begin
				burst = RANDOM_ITEMS - sent;
			end
			repeat (burst) begin
				send_word(random_op(mode), random_value(), 1'b0, no_view);
				sent++;
			end
		end
		no_idle = 1'b0;
		cmd_ch.valid <= 1'b0;

		// Wait for every result, then leave time for any stray word to appear.
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Result side: ready is dropped for random stretches, except in bursts where
	// no idling is wanted. Ready goes low and comes back high in different steps.
	initial begin : rsp_sink
		int unsigned run;
		rsp_ch.ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			run = no_idle ? 0 : pick_gap();
			if (run != 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (run) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	end

	// Each result word taken is compared field by field with the oldest one due.
	always @(posedge clk) begin : rsp_check
		list_view_t due;
		if (rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result word with none due: status %0d count %0d", rsp_ch.status,
					rsp_ch.count);
				fail_count++;
			end else begin
				due = pending_results.pop_front();
				if (rsp_ch.status !== due.status) begin
					$error("status: expected %0d, got %0d", due.status, rsp_ch.status);
					fail_count++;
				end
				if (rsp_ch.count !== due.count) begin
					$error("count: expected %0d, got %0d", due.count, rsp_ch.count);
					fail_count++;
				end
				if (rsp_ch.cursor_position !== due.cursor_position) begin
					$error("cursor_position: expected %0d, got %0d", due.cursor_position,
						rsp_ch.cursor_position);
					fail_count++;
				end
				if (rsp_ch.front_value !== due.front_value) begin
					$error("front_value: expected %0d, got %0d", due.front_value,
						rsp_ch.front_value);
					fail_count++;
				end
				if (rsp_ch.back_value !== due.back_value) begin
					$error("back_value: expected %0d, got %0d", due.back_value,
						rsp_ch.back_value);
					fail_count++;
				end
				if (rsp_ch.cursor_value !== due.cursor_value) begin
					$error("cursor_value: expected %0d, got %0d", due.cursor_value,
						rsp_ch.cursor_value);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: a run in which no word moves on either channel for too long has hung.
	initial begin
		quiet_cycles = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

endmodule
